// ===== hdl/pcba_pkg.sv =====
package pcba_pkg;

    // Field widths of one input word and one output word
    localparam int COLOR_W   = 8;
    localparam int SEL_W     = 2;
    localparam int CFG_SIDE_W = 13;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW  = 8;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_CAL_ENABLE   = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // Command codes carried in tuser
    localparam logic CMD_PIXEL       = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    // Calibration table selects
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] SEL_RED   = 2'd2;

    localparam logic [CFG_SIDE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_SIDE_W-1:0] HEIGHT_RESET = 13'd480;

endpackage

// ===== hdl/pixel_calibrate_border_alpha_unit.sv =====
// An accepted pixel word passes the stage-one registers, then the output register.
// Throughput: one word per clock while the master side is not stalled.
// Table write words produce no output word.
// Reset: counters, valid flags and config registers return to their defaults at once;
// table contents are undefined until written and get no clearing pass.
module pixel_calibrate_border_alpha_unit #(
    parameter int BORDER   = 32,
    parameter int MAX_SIDE = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: red[7:0], green[15:8], blue[23:16], mask_level[31:24],
    //          table_select[33:32], table_index[41:34], table_value[49:42], zero pad
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pcba_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: command
    input  logic                                s_tuser,
    // m_tdata: out_red[7:0], out_green[15:8], out_blue[23:16],
    //          front_alpha[31:24], back_alpha[39:32]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcba_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tlast: frame_end
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcba_pkg::APB_AW-1:0]         paddr,
    input  logic [pcba_pkg::APB_DW-1:0]         pwdata,
    output logic [pcba_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int CNT_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);

    typedef logic [pcba_pkg::COLOR_W-1:0] ramp_table_t [pcba_pkg::TABLE_DEPTH];

    function automatic ramp_table_t build_ramp();
        ramp_table_t t;
        for (int k = 0; k < pcba_pkg::TABLE_DEPTH; k++)
        begin
            t[k] = pcba_pkg::COLOR_W'((k * 255) / BORDER);
        end
        return t;
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_side(logic [pcba_pkg::CFG_SIDE_W-1:0] raw);
        logic [SIDE_W-1:0] v;
        if (raw == '0)
        begin
            v = SIDE_W'(1);
        end
        else if (raw > pcba_pkg::CFG_SIDE_W'(MAX_SIDE))
        begin
            v = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            v = SIDE_W'(raw);
        end
        return v;
    endfunction

    localparam ramp_table_t RAMP_TABLE = build_ramp();

    typedef struct packed {
        logic                         cal_en;
        logic [pcba_pkg::COLOR_W-1:0] red;
        logic [pcba_pkg::COLOR_W-1:0] green;
        logic [pcba_pkg::COLOR_W-1:0] blue;
        logic [pcba_pkg::COLOR_W-1:0] mask;
        logic                         ramp_sel;
        logic [pcba_pkg::COLOR_W-1:0] ramp_idx;
        logic                         frame_last;
    } stage_t;

    // Input word fields
    logic [pcba_pkg::COLOR_W-1:0]  in_red, in_green, in_blue, in_mask;
    logic [pcba_pkg::SEL_W-1:0]    in_sel;
    logic [pcba_pkg::TABLE_AW-1:0] in_idx;
    logic [pcba_pkg::COLOR_W-1:0]  in_val;

    assign in_red   = s_tdata[7:0];
    assign in_green = s_tdata[15:8];
    assign in_blue  = s_tdata[23:16];
    assign in_mask  = s_tdata[31:24];
    assign in_sel   = s_tdata[33:32];
    assign in_idx   = s_tdata[41:34];
    assign in_val   = s_tdata[49:42];

    // Configuration registers
    logic                              cal_en_reg;
    logic [pcba_pkg::CFG_SIDE_W-1:0]   width_raw_reg, height_raw_reg;
    logic [SIDE_W-1:0]                 width_eff_reg, height_eff_reg;
    logic                              cfg_write;
    logic [1:0]                        cfg_reg_idx;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign cfg_reg_idx = paddr[3:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_en_reg     <= 1'b0;
            width_raw_reg  <= pcba_pkg::WIDTH_RESET;
            height_raw_reg <= pcba_pkg::HEIGHT_RESET;
            width_eff_reg  <= clamp_side(pcba_pkg::WIDTH_RESET);
            height_eff_reg <= clamp_side(pcba_pkg::HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_idx)
                pcba_pkg::REG_CAL_ENABLE:
                begin
                    cal_en_reg <= pwdata[0];
                end
                pcba_pkg::REG_FRAME_WIDTH:
                begin
                    width_raw_reg <= pwdata[pcba_pkg::CFG_SIDE_W-1:0];
                    width_eff_reg <= clamp_side(pwdata[pcba_pkg::CFG_SIDE_W-1:0]);
                end
                pcba_pkg::REG_FRAME_HEIGHT:
                begin
                    height_raw_reg <= pwdata[pcba_pkg::CFG_SIDE_W-1:0];
                    height_eff_reg <= clamp_side(pwdata[pcba_pkg::CFG_SIDE_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read back configuration
    always_comb
    begin
        unique case (cfg_reg_idx)
            pcba_pkg::REG_CAL_ENABLE:   prdata = pcba_pkg::APB_DW'(cal_en_reg);
            pcba_pkg::REG_FRAME_WIDTH:  prdata = pcba_pkg::APB_DW'(width_raw_reg);
            pcba_pkg::REG_FRAME_HEIGHT: prdata = pcba_pkg::APB_DW'(height_raw_reg);
            default:                    prdata = '0;
        endcase
    end

    // Handshake and pipeline control
    logic   s1_valid_reg;
    stage_t s1_reg;
    logic   advance;
    logic   in_accept;
    logic   pix_accept;
    logic   tbl_accept;

    assign advance    = !m_tvalid || m_tready;
    assign s_tready   = !s1_valid_reg || advance;
    assign in_accept  = s_tvalid && s_tready;
    assign pix_accept = in_accept && (s_tuser == pcba_pkg::CMD_PIXEL);
    assign tbl_accept = in_accept && (s_tuser == pcba_pkg::CMD_TABLE_WRITE);

    // Calibration table RAMs: write on a table word, read on a pixel word
    logic [pcba_pkg::COLOR_W-1:0] red_mem   [pcba_pkg::TABLE_DEPTH];
    logic [pcba_pkg::COLOR_W-1:0] green_mem [pcba_pkg::TABLE_DEPTH];
    logic [pcba_pkg::COLOR_W-1:0] blue_mem  [pcba_pkg::TABLE_DEPTH];
    logic [pcba_pkg::COLOR_W-1:0] red_rd_reg, green_rd_reg, blue_rd_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_accept && (in_sel == pcba_pkg::SEL_RED))
        begin
            red_mem[in_idx] <= in_val;
        end
        if (pix_accept)
        begin
            red_rd_reg <= red_mem[in_red];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_accept && (in_sel == pcba_pkg::SEL_GREEN))
        begin
            green_mem[in_idx] <= in_val;
        end
        if (pix_accept)
        begin
            green_rd_reg <= green_mem[in_green];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_accept && (in_sel == pcba_pkg::SEL_BLUE))
        begin
            blue_mem[in_idx] <= in_val;
        end
        if (pix_accept)
        begin
            blue_rd_reg <= blue_mem[in_blue];
        end
    end

    // Border distance and frame position
    logic [CNT_W-1:0]  row_reg, col_reg, row_next, col_next;
    logic [SIDE_W-1:0] row_ext, col_ext, row_far, col_far, vdist, hdist, near_dist;
    logic              dist_in_border, row_last, frame_last;

    always_comb
    begin
        row_ext = SIDE_W'(row_reg);
        col_ext = SIDE_W'(col_reg);
        row_far = (row_ext < height_eff_reg) ? height_eff_reg - row_ext : '0;
        col_far = (col_ext < width_eff_reg) ? width_eff_reg - col_ext : '0;
        vdist   = (row_ext < row_far) ? row_ext : row_far;
        hdist   = (col_ext < col_far) ? col_ext : col_far;
        near_dist = (vdist < hdist) ? vdist : hdist;
        dist_in_border = (32'(near_dist) <= 32'(BORDER));
        row_last   = col_ext >= (width_eff_reg - SIDE_W'(1));
        frame_last = row_last && (row_ext >= (height_eff_reg - SIDE_W'(1)));
        if (row_last)
        begin
            col_next = '0;
            row_next = frame_last ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    // Advance counters on each pixel word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (pix_accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Stage one: hold pixel fields beside the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= pix_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_reg.cal_en     <= cal_en_reg;
            s1_reg.red        <= in_red;
            s1_reg.green      <= in_green;
            s1_reg.blue       <= in_blue;
            s1_reg.mask       <= in_mask;
            s1_reg.ramp_sel   <= dist_in_border;
            s1_reg.ramp_idx   <= pcba_pkg::COLOR_W'(near_dist);
            s1_reg.frame_last <= frame_last;
        end
    end

    // Stage two: select colors, form background alpha, load output register
    logic [pcba_pkg::COLOR_W-1:0] out_red, out_green, out_blue, back_alpha;
    logic [pcba_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tvalid_reg, m_tlast_reg;

    always_comb
    begin
        out_red    = s1_reg.cal_en ? red_rd_reg   : s1_reg.red;
        out_green  = s1_reg.cal_en ? green_rd_reg : s1_reg.green;
        out_blue   = s1_reg.cal_en ? blue_rd_reg  : s1_reg.blue;
        back_alpha = s1_reg.ramp_sel ? RAMP_TABLE[s1_reg.ramp_idx]
                                     : ~s1_reg.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            m_tdata_reg <= {back_alpha, s1_reg.mask, out_blue, out_green, out_red};
            m_tlast_reg <= s1_reg.frame_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Table writes never launch an output word
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_accept |=> !s1_valid_reg)
        else $error("table write launched a pixel word");

    // Last pixel of a frame returns both counters to the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && frame_last) |=> (row_reg == '0 && col_reg == '0))
        else $error("counters not cleared after frame end");

    // Column steps by one inside a row
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && !row_last) |=> (col_reg == $past(col_reg) + CNT_W'(1)))
        else $error("column counter skipped");

    // A full pipeline with a stalled output takes no new word
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("word accepted into a full pipeline");

endmodule

// ===== tb/pixel_calibrate_border_alpha_unit_test.sv =====
module pixel_calibrate_border_alpha_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BORDER   = 32;
    localparam int MAX_SIDE = 4096;

    // Select code that hits no table, and the register index past the last one
    localparam logic [pcba_pkg::SEL_W-1:0] SEL_NONE  = 2'd3;
    localparam logic [1:0]                 REG_SPARE = 2'd3;

    typedef struct {
        logic                          cmd;
        logic [pcba_pkg::COLOR_W-1:0]  red;
        logic [pcba_pkg::COLOR_W-1:0]  green;
        logic [pcba_pkg::COLOR_W-1:0]  blue;
        logic [pcba_pkg::COLOR_W-1:0]  mask;
        logic [pcba_pkg::SEL_W-1:0]    table_sel;
        logic [pcba_pkg::TABLE_AW-1:0] entry;
        logic [pcba_pkg::COLOR_W-1:0]  entry_value;
    } pixel_word_t;

    typedef struct {
        logic [pcba_pkg::COLOR_W-1:0] red;
        logic [pcba_pkg::COLOR_W-1:0] green;
        logic [pcba_pkg::COLOR_W-1:0] blue;
        logic [pcba_pkg::COLOR_W-1:0] front_alpha;
        logic [pcba_pkg::COLOR_W-1:0] back_alpha;
        logic                         frame_end;
    } shade_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pcba_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = pcba_pkg::CMD_PIXEL;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pcba_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [pcba_pkg::APB_AW-1:0]    paddr    = '0;
    logic [pcba_pkg::APB_DW-1:0]    pwdata   = '0;
    logic [pcba_pkg::APB_DW-1:0]    prdata;
    logic                           pready;

    // Words waiting for the driver, and shades waiting for the output side
    pixel_word_t pending_words[$];
    shade_t      expected_shades[$];
    pixel_word_t cur_word;
    bit          word_taken = 1'b0;
    int          send_gap   = 0;
    int          sink_stall = 0;
    int          busy_rate  = 0;

    // Predictor state: shadow registers, tables and raster position
    logic                            cal_on     = 1'b0;
    logic [pcba_pkg::CFG_SIDE_W-1:0] width_reg  = pcba_pkg::WIDTH_RESET;
    logic [pcba_pkg::CFG_SIDE_W-1:0] height_reg = pcba_pkg::HEIGHT_RESET;
    logic [pcba_pkg::COLOR_W-1:0]    calib_table [3][pcba_pkg::TABLE_DEPTH];
    int                              row_pos    = 0;
    int                              col_pos    = 0;

    // Entries written so far, as seen by the stimulus generator
    bit table_written [3][pcba_pkg::TABLE_DEPTH];

    int mismatch_count = 0;
    int pixel_words    = 0;
    int table_words    = 0;
    int shades_checked = 0;
    int frame_ends     = 0;
    int settings_count = 0;

    pixel_calibrate_border_alpha_unit #(
        .BORDER   (BORDER),
        .MAX_SIDE (MAX_SIDE)
    ) dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_side(input logic [pcba_pkg::CFG_SIDE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return int'(v);
    endfunction

    // Apply one accepted word to the predictor; pixels queue a shade
    task automatic predict_word(input pixel_word_t w);
        int     side_w;
        int     side_h;
        int     vdist;
        int     hdist;
        int     near_dist;
        logic   row_last;
        shade_t s;
        if (w.cmd == pcba_pkg::CMD_TABLE_WRITE)
        begin
            if (w.table_sel != SEL_NONE)
                calib_table[w.table_sel][w.entry] = w.entry_value;
        end
        else
        begin
            side_w = clamp_side(width_reg);
            side_h = clamp_side(height_reg);
            s.red   = cal_on ? calib_table[pcba_pkg::SEL_RED][w.red]     : w.red;
            s.green = cal_on ? calib_table[pcba_pkg::SEL_GREEN][w.green] : w.green;
            s.blue  = cal_on ? calib_table[pcba_pkg::SEL_BLUE][w.blue]   : w.blue;
            s.front_alpha = w.mask;

            // Distance to the nearest edge; far edge counts zero past the frame
            vdist = (row_pos < side_h) ? side_h - row_pos : 0;
            if (row_pos < vdist)
                vdist = row_pos;
            hdist = (col_pos < side_w) ? side_w - col_pos : 0;
            if (col_pos < hdist)
                hdist = col_pos;
            near_dist = (vdist < hdist) ? vdist : hdist;
            if (near_dist <= BORDER)
                s.back_alpha = 8'(near_dist * 255 / BORDER);
            else
                s.back_alpha = 8'(255 - int'(w.mask));

            row_last    = (col_pos >= side_w - 1);
            s.frame_end = row_last && (row_pos >= side_h - 1);
            expected_shades.push_back(s);

            // Advance the raster position
            if (row_last)
            begin
                col_pos = 0;
                row_pos = s.frame_end ? 0 : (row_pos + 1) & 12'hFFF;
            end
            else
                col_pos = (col_pos + 1) & 12'hFFF;
        end
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Drive the input side; hold a word until it is taken
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = 1'b0;
        if (!rst_n)
            next_valid = 1'b0;
        else if (s_tvalid && !word_taken)
            next_valid = 1'b1;
        else if (send_gap > 0)
            send_gap--;
        else if (pending_words.size() != 0 && $urandom_range(0, 99) < busy_rate)
            send_gap = $urandom_range(0, 12);
        else if (pending_words.size() != 0)
        begin
            cur_word   = pending_words.pop_front();
            next_valid = 1'b1;
            s_tdata <= {{(pcba_pkg::S_TDATA_W - 50){1'b0}}, cur_word.entry_value,
                        cur_word.entry, cur_word.table_sel, cur_word.mask, cur_word.blue,
                        cur_word.green, cur_word.red};
            s_tuser <= cur_word.cmd;
        end
        word_taken = 1'b0;
        s_tvalid <= next_valid;
    end

    // Stall the output side in bursts
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < busy_rate)
        begin
            sink_stall = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Predict on accepted input words, check accepted output words
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_word(cur_word);
                word_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_shades.size() == 0)
                begin
                    $display("%0t ns: output word with nothing expected, got %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_shades.pop_front();
                    check_field("out_red",     want.red,         m_tdata[7:0]);
                    check_field("out_green",   want.green,       m_tdata[15:8]);
                    check_field("out_blue",    want.blue,        m_tdata[23:16]);
                    check_field("front_alpha", want.front_alpha, m_tdata[31:24]);
                    check_field("back_alpha",  want.back_alpha,  m_tdata[39:32]);
                    check_field("frame_end",   8'(want.frame_end), 8'(m_tlast));
                    shades_checked++;
                    if (m_tlast === 1'b1)
                        frame_ends++;
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] reg_index,
                             input logic [pcba_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_index)
            pcba_pkg::REG_CAL_ENABLE:   cal_on     = data[0];
            pcba_pkg::REG_FRAME_WIDTH:  width_reg  = data[pcba_pkg::CFG_SIDE_W-1:0];
            pcba_pkg::REG_FRAME_HEIGHT: height_reg = data[pcba_pkg::CFG_SIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] m);
        pixel_word_t w;
        w.cmd         = pcba_pkg::CMD_PIXEL;
        w.red         = r;
        w.green       = g;
        w.blue        = b;
        w.mask        = m;
        w.table_sel   = 2'($urandom_range(0, 3));
        w.entry       = 8'($urandom_range(0, 255));
        w.entry_value = 8'($urandom_range(0, 255));
        pending_words.push_back(w);
        pixel_words++;
    endtask

    task automatic queue_table_write(input logic [pcba_pkg::SEL_W-1:0] tsel,
                                     input logic [7:0] idx, input logic [7:0] val);
        pixel_word_t w;
        w.cmd         = pcba_pkg::CMD_TABLE_WRITE;
        w.red         = 8'($urandom_range(0, 255));
        w.green       = 8'($urandom_range(0, 255));
        w.blue        = 8'($urandom_range(0, 255));
        w.mask        = 8'($urandom_range(0, 255));
        w.table_sel   = tsel;
        w.entry       = idx;
        w.entry_value = val;
        pending_words.push_back(w);
        if (tsel != SEL_NONE)
            table_written[tsel][idx] = 1'b1;
        table_words++;
    endtask

    // With calibration on, steer a color to an entry already written
    function automatic logic [7:0] pick_color(input logic [pcba_pkg::SEL_W-1:0] tsel);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (cal_on)
            while (!table_written[tsel][c])
                c++;
        return c;
    endfunction

    task automatic queue_random(input int pixels);
        int placed;
        placed = 0;
        while (placed < pixels)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_table_write(($urandom_range(0, 15) == 0) ? SEL_NONE
                                                               : 2'($urandom_range(0, 2)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
            begin
                queue_pixel(pick_color(pcba_pkg::SEL_RED), pick_color(pcba_pkg::SEL_GREEN),
                            pick_color(pcba_pkg::SEL_BLUE), 8'($urandom_range(0, 255)));
                placed++;
            end
        end
    endtask

    // Wait until no word is pending or in flight, then let the pipeline settle
    task automatic wait_until_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || s_tvalid || expected_shades.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [pcba_pkg::APB_DW-1:0] cal_data,
                             input logic [pcba_pkg::APB_DW-1:0] width_data,
                             input logic [pcba_pkg::APB_DW-1:0] height_data,
                             input int pixels, input int idle_pct);
        wait_until_drained();
        apb_write(pcba_pkg::REG_CAL_ENABLE, cal_data);
        apb_write(pcba_pkg::REG_FRAME_WIDTH, width_data);
        apb_write(pcba_pkg::REG_FRAME_HEIGHT, height_data);
        settings_count++;
        busy_rate = idle_pct;
        queue_random(pixels);
    endtask

    initial
    begin
        logic [pcba_pkg::APB_DW-1:0] rand_w;
        logic [pcba_pkg::APB_DW-1:0] rand_h;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words under reset settings: table extremes, ignored select, pixels
        busy_rate = 15;
        queue_table_write(pcba_pkg::SEL_BLUE,  8'd0,   8'd255);
        queue_table_write(pcba_pkg::SEL_BLUE,  8'd255, 8'd0);
        queue_table_write(pcba_pkg::SEL_GREEN, 8'd0,   8'd255);
        queue_table_write(pcba_pkg::SEL_GREEN, 8'd255, 8'd0);
        queue_table_write(pcba_pkg::SEL_RED,   8'd0,   8'd255);
        queue_table_write(pcba_pkg::SEL_RED,   8'd255, 8'd0);
        queue_table_write(SEL_NONE,            8'd128, 8'hAA);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
        queue_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        queue_random(20);

        // One-pixel rows climb the row counter past the border
        run_phase(32'd1, 32'd1, 32'd4096, 0, 10);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_random(38);
        // Wide frame from a deep row reaches the inverted-mask region
        run_phase(32'd1, 32'd100, 32'd100, 120, 20);
        // Shrink mid-frame so the counters sit past the new frame
        wait_until_drained();
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        run_phase(32'd0, 32'd10, 32'd20, 40, 25);
        // Boundary sizes: zero, the largest side, and above the largest side
        run_phase(32'd1, 32'd0, 32'd0, 30, 10);
        run_phase(32'd0, 32'd8191, 32'd8191, 40, 0);
        run_phase(32'd1, 32'd4096, 32'd1, 30, 15);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_F000, 32'hFFFF_F000, 20, 20);

        // Random small frames, now and then degenerate or oversized
        repeat (11)
        begin
            case ($urandom_range(0, 7))
                0:       rand_w = 32'd0;
                1:       rand_w = 32'($urandom_range(4097, 8191));
                default: rand_w = 32'($urandom_range(1, 9));
            endcase
            case ($urandom_range(0, 7))
                0:       rand_h = 32'd0;
                1:       rand_h = 32'($urandom_range(4097, 8191));
                default: rand_h = 32'($urandom_range(1, 6));
            endcase
            run_phase($urandom(), rand_w, rand_h, 40,
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30));
        end

        // Close with full-rate traffic on both sides
        run_phase(32'($urandom_range(0, 1)), 32'd3, 32'd4, 80, 0);
        wait_until_drained();
        repeat (4) @(posedge clk);

        $display("Ran %0d pixel and %0d table words across %0d frame settings.",
                 pixel_words, table_words, settings_count);
        $display("Checked %0d result words, %0d of them frame ends; %0d mismatches.",
                 shades_checked, frame_ends, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS pixel_calibrate_border_alpha_unit");
        else
            $display("FAIL pixel_calibrate_border_alpha_unit");
        $finish;
    end

    // Bound the run in case the stream stalls
    initial
    begin
        #1_000_000;
        $display("%0t ns: timeout with %0d words pending and %0d results outstanding",
                 $time, pending_words.size(), expected_shades.size());
        $display("FAIL pixel_calibrate_border_alpha_unit");
        $finish;
    end

endmodule
